// ----- src/task_liveness_watchdog_core_defines.svh -----
// Assertion macros shared by the watchdog RTL.
`ifndef TASK_LIVENESS_WATCHDOG_CORE_DEFINES_SVH
`define TASK_LIVENESS_WATCHDOG_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TLW_ASSERT_NOW(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLW_ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error(msg);

`endif

// ----- src/tlw_pkg.sv -----
`default_nettype none
package tlw_pkg;

  localparam int unsigned TICK_W          = 32;
  localparam int unsigned SLOT_W          = 3;
  localparam int unsigned ACTION_W        = 2;
  localparam int unsigned VERDICT_W       = 2;
  localparam int unsigned NUM_REGS        = 8;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned CFG_ADDR_W      = 5;
  localparam int unsigned MONITORED_SLOTS = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CHECK_IN  = 2'd0,
    ACT_CHECK_OUT = 2'd1,
    ACT_REPORT    = 2'd2,
    ACT_CHECK     = 2'd3
  } action_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_PASS = 2'd1,
    VERDICT_FAIL = 2'd2
  } verdict_t;

  // Slot update broadcast to one cell; wr_flag low keeps the stored flag
  typedef struct packed {
    logic              en;
    logic              wr_flag;
    logic              flag;
    logic [TICK_W-1:0] ticks;
  } upd_t;

  // Scan probe passed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [TICK_W-1:0] now_ticks;
    logic              found;
    logic [SLOT_W-1:0] fslot;
    logic [SLOT_W-1:0] pos;
  } probe_t;

endpackage
`default_nettype wire

// ----- src/tlw_in_if.sv -----
`default_nettype none
interface tlw_in_if;
  logic                          valid;
  logic                          ready;
  logic [tlw_pkg::ACTION_W-1:0]  action;
  logic [tlw_pkg::SLOT_W-1:0]    slot;
  logic [tlw_pkg::TICK_W-1:0]    now_ticks;

  modport source (output valid, action, slot, now_ticks, input ready);
  modport sink   (input valid, action, slot, now_ticks, output ready);
endinterface
`default_nettype wire

// ----- src/tlw_out_if.sv -----
`default_nettype none
interface tlw_out_if;
  logic                          valid;
  logic                          ready;
  logic [tlw_pkg::VERDICT_W-1:0] verdict;
  logic [tlw_pkg::SLOT_W-1:0]    failing_slot;

  modport source (output valid, verdict, failing_slot, input ready);
  modport sink   (input valid, verdict, failing_slot, output ready);
endinterface
`default_nettype wire

// ----- src/tlw_cell.sv -----
`default_nettype none
module tlw_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tlw_pkg::upd_t              upd_i,
  input  logic [tlw_pkg::TICK_W-1:0] allowed_i,
  input  tlw_pkg::probe_t            probe_i,
  output tlw_pkg::probe_t            probe_o
);

  logic                       ci_r;
  logic [tlw_pkg::TICK_W-1:0] lrt_r;
  logic                       valid_r;
  tlw_pkg::probe_t            data_r;

  logic [tlw_pkg::TICK_W-1:0] elapsed;
  logic                       fault;
  tlw_pkg::probe_t            probe_nxt;

  // Judge this slot against the passing probe
  always_comb begin
    elapsed = probe_i.now_ticks - lrt_r;
    if (!ci_r) begin
      fault = (lrt_r != '0);
    end else begin
      fault = (lrt_r == '0) || (elapsed > allowed_i);
    end
    probe_nxt           = probe_i;
    probe_nxt.found     = probe_i.found | fault;
    probe_nxt.fslot     = probe_i.found ? probe_i.fslot : probe_i.pos;
    probe_nxt.pos       = probe_i.pos + tlw_pkg::SLOT_W'(1);
  end

  // Hold slot state, apply updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ci_r    <= 1'b0;
      lrt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (upd_i.en) begin
        if (upd_i.wr_flag) begin
          ci_r <= upd_i.flag;
        end
        lrt_r <= upd_i.ticks;
      end
      valid_r <= probe_i.valid;
    end
  end

  // Advance probe payload to the neighbor
  always_ff @(posedge clk) begin
    data_r <= probe_nxt;
  end

  always_comb begin
    probe_o       = data_r;
    probe_o.valid = valid_r;
  end

endmodule
`default_nettype wire

// ----- src/task_liveness_watchdog_core.sv -----
//  channel | direction | beat fields
//  --------+-----------+--------------------------------------------
//  in_ch   | sink      | action, slot, now_ticks
//  out_ch  | source    | verdict, failing_slot
//  apb     | slave     | allowed_time_0..7 at 4*i (write and read)
//
//  Check-in, check-out, running report and a wrapped check load the
//  result register at the accept edge.
//  A full check walks a probe down the row of MONITORED_SLOTS cells, one
//  cell per cycle, launch register first and result register last.
//  One item is in flight at a time; in_ch is held off during a scan and
//  while an undrained result sits in the output register.
//  Reset (rst_n low, synchronous) clears all slots and restores the limits.
`default_nettype none
`include "task_liveness_watchdog_core_defines.svh"
module task_liveness_watchdog_core #(
  parameter int unsigned MONITORED_SLOTS = tlw_pkg::MONITORED_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tlw_in_if.sink                         in_ch,
  tlw_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tlw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tlw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int unsigned IDX_W = tlw_pkg::CFG_ADDR_W - 2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [tlw_pkg::TICK_W-1:0] allowed_r [tlw_pkg::NUM_REGS];
  logic [tlw_pkg::TICK_W-1:0] prev_check_r;
  logic [IDX_W-1:0]           cfg_idx;
  logic                       cfg_wr;

  logic                          out_valid_r, out_valid_nxt;
  logic [tlw_pkg::VERDICT_W-1:0] verdict_r, verdict_nxt;
  logic [tlw_pkg::SLOT_W-1:0]    fslot_r, fslot_nxt;

  logic            launch_valid_r;
  tlw_pkg::probe_t launch_data_r;
  tlw_pkg::probe_t launch_probe;
  tlw_pkg::probe_t launch_nxt;

  tlw_pkg::probe_t chain [MONITORED_SLOTS];
  tlw_pkg::upd_t   upd   [MONITORED_SLOTS];
  tlw_pkg::probe_t tail;
  logic [MONITORED_SLOTS:0] probe_valids;

  logic             in_fire;
  logic             is_check;
  logic             wrapped;
  logic             upd_flag;
  tlw_pkg::action_t act;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[tlw_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = allowed_r[cfg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tlw_pkg::NUM_REGS; i++) begin
        allowed_r[i] <= '1;
      end
    end else if (cfg_wr) begin
      allowed_r[cfg_idx] <= pwdata;
    end
  end

  // Input decode
  assign act      = tlw_pkg::action_t'(in_ch.action);
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign is_check = (act == tlw_pkg::ACT_CHECK);
  assign wrapped  = in_ch.now_ticks < prev_check_r;

  always_comb begin
    unique case (act)
      tlw_pkg::ACT_CHECK_IN:  upd_flag = 1'b1;
      tlw_pkg::ACT_CHECK_OUT: upd_flag = 1'b0;
      tlw_pkg::ACT_REPORT:    upd_flag = 1'b1;
      tlw_pkg::ACT_CHECK:     upd_flag = 1'b0;
      default:                upd_flag = 1'b0;
    endcase
  end

  // Broadcast slot updates; a report keeps the flag, check-out zeroes the time
  generate
    for (genvar i = 0; i < MONITORED_SLOTS; i++) begin : g_upd
      always_comb begin
        upd[i].en      = in_fire && !is_check &&
                         (in_ch.slot == tlw_pkg::SLOT_W'(i));
        upd[i].wr_flag = (act != tlw_pkg::ACT_REPORT);
        upd[i].flag    = upd_flag;
        upd[i].ticks   = (act == tlw_pkg::ACT_CHECK_OUT) ? '0 : in_ch.now_ticks;
      end
    end
  endgenerate

  // Row of slot cells
  generate
    for (genvar i = 0; i < MONITORED_SLOTS; i++) begin : g_cell
      if (i == 0) begin : g_head
        tlw_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .upd_i     (upd[i]),
          .allowed_i (allowed_r[i]),
          .probe_i   (launch_probe),
          .probe_o   (chain[i])
        );
      end else begin : g_body
        tlw_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .upd_i     (upd[i]),
          .allowed_i (allowed_r[i]),
          .probe_i   (chain[i-1]),
          .probe_o   (chain[i])
        );
      end
    end
  endgenerate

  assign tail = chain[MONITORED_SLOTS-1];

  // Probe launch for a full check
  always_comb begin
    launch_nxt           = '0;
    launch_nxt.valid     = 1'b1;
    launch_nxt.now_ticks = in_ch.now_ticks;
  end

  always_ff @(posedge clk) begin
    launch_data_r <= launch_nxt;
  end

  always_comb begin
    launch_probe       = launch_data_r;
    launch_probe.valid = launch_valid_r;
  end

  // Control and result register
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    verdict_nxt   = verdict_r;
    fslot_nxt     = fslot_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!is_check) begin
            out_valid_nxt = 1'b1;
            verdict_nxt   = tlw_pkg::VERDICT_NONE;
            fslot_nxt     = '0;
          end else if (wrapped) begin
            out_valid_nxt = 1'b1;
            verdict_nxt   = tlw_pkg::VERDICT_PASS;
            fslot_nxt     = '0;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (tail.valid) begin
          out_valid_nxt = 1'b1;
          verdict_nxt   = tail.found ? tlw_pkg::VERDICT_FAIL : tlw_pkg::VERDICT_PASS;
          fslot_nxt     = tail.found ? tail.fslot : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      launch_valid_r <= 1'b0;
      prev_check_r   <= '0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      launch_valid_r <= in_fire && is_check && !wrapped;
      if (in_fire && is_check && !wrapped) begin
        prev_check_r <= in_ch.now_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
    fslot_r   <= fslot_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.verdict      = verdict_r;
  assign out_ch.failing_slot = fslot_r;

  // Probe valids along the row, for checking
  always_comb begin
    probe_valids[0] = launch_valid_r;
    for (int i = 0; i < MONITORED_SLOTS; i++) begin
      probe_valids[i+1] = chain[i].valid;
    end
  end

  `TLW_ASSERT_NOW(a_scan_out_empty, state_r == ST_SCAN, !out_valid_r, "result pending during scan")
  `TLW_ASSERT_NOW(a_one_probe, 1'b1, $onehot0(probe_valids), "more than one probe in the row")
  `TLW_ASSERT_NEXT(a_tail_loads, state_r == ST_SCAN && tail.valid, out_valid_r, "scan result lost")
  `TLW_ASSERT_NEXT(a_launch, in_fire && is_check && !wrapped, launch_valid_r && state_r == ST_SCAN, "check did not launch a scan")

endmodule
`default_nettype wire
